// File: rtl/tile_pixel_unpacker_core_defines.svh
// assertion macros shared by the tile pixel unpacker rtl
// expects clk and rst to be visible where a macro is used
`ifndef TILE_PIXEL_UNPACKER_CORE_DEFINES_SVH
`define TILE_PIXEL_UNPACKER_CORE_DEFINES_SVH

// checked on every edge outside reset
`define TPU_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// implication checked on every edge outside reset
`define TPU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tpu_pkg.sv
// types, constants and helpers for the tile pixel unpacker
// no dependencies
package tpu_pkg;

  localparam int unsigned SIDE_CFG_W   = 5;
  localparam int unsigned COUNT_W      = 13;
  localparam int unsigned ROW_W        = 7;
  localparam int unsigned COORD_W      = 10;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 13;

  localparam int unsigned DEF_MAX_TILES_PER_ROW = 64;
  localparam int unsigned DEF_MAX_TILE_SIDE     = 16;
  localparam int unsigned DEF_QUEUE_DEPTH       = 2;

  localparam logic [SIDE_CFG_W-1:0] RST_TILE_WIDTH  = 5'd8;
  localparam logic [SIDE_CFG_W-1:0] RST_TILE_HEIGHT = 5'd8;
  localparam logic [COUNT_W-1:0]    RST_TILE_COUNT  = 13'd1;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT  = 2'd2;

  localparam int unsigned SCALE3 = 255 / 7;
  localparam int unsigned SCALE2 = 255 / 3;

  // one classified pixel waiting for colour expansion
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pix;
    logic               done;
  } tpu_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tpu_qstat_t;

  function automatic logic [CHAN_W-1:0] expand3(input logic [2:0] v);
    expand3 = CHAN_W'(int'(v) * SCALE3);
  endfunction

  function automatic logic [CHAN_W-1:0] expand2(input logic [1:0] v);
    expand2 = CHAN_W'(int'(v) * SCALE2);
  endfunction

endpackage

// File: rtl/tile_pixel_unpacker_core.sv
// Tile pixel unpacker: takes one BBGGGRRR tile byte per clock while in_ready is
// high and returns its image position and 24-bit colour. The front end places
// each byte (and drops bytes past the sheet) in the cycle it is accepted and
// writes it into a two-entry register queue; the back end expands the colour
// into the output register. A sustained rate of one pixel per clock holds while
// out_ready is high; each byte is held in the queue and then in the output
// register before out_valid shows it, and in_ready falls only when the queue is
// full. Configuration writes restart the layout at tile zero and must be made
// while the block is idle.
// depends on tpu_pkg, tpu_front, tpu_queue and tpu_back
module tile_pixel_unpacker_core import tpu_pkg::*; #(
  parameter int unsigned MAX_TILES_PER_ROW = DEF_MAX_TILES_PER_ROW,
  parameter int unsigned MAX_TILE_SIDE     = DEF_MAX_TILE_SIDE,
  parameter int unsigned QUEUE_DEPTH       = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      pixel_byte,
  input  logic                  first,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_W-1:0]    pixel_x,
  output logic [COORD_W-1:0]    pixel_y,
  output logic [CHAN_W-1:0]     red,
  output logic [CHAN_W-1:0]     green,
  output logic [CHAN_W-1:0]     blue,
  output logic                  sheet_done
);

  tpu_qstat_t q_stat;
  tpu_item_t  push_item, head_item;
  logic       q_push, q_pop;

  tpu_front #(
    .MAX_TILES_PER_ROW(MAX_TILES_PER_ROW),
    .MAX_TILE_SIDE    (MAX_TILE_SIDE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_byte(pixel_byte),
    .first     (first),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  tpu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .head_item(head_item),
    .stat     (q_stat)
  );

  tpu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_item (head_item),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .sheet_done(sheet_done)
  );

endmodule

// File: rtl/tpu_front.sv
// front end: configuration registers, layout counters, position and drop decision
// depends on tpu_pkg
module tpu_front import tpu_pkg::*; #(
  parameter int unsigned MAX_TILES_PER_ROW = DEF_MAX_TILES_PER_ROW,
  parameter int unsigned MAX_TILE_SIDE     = DEF_MAX_TILE_SIDE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      pixel_byte,
  input  logic                  first,
  input  tpu_qstat_t            q_stat,
  output logic                  q_push,
  output tpu_item_t             q_item
);

  localparam int unsigned SIDE_W = $clog2(MAX_TILE_SIDE + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_TILE_SIDE);
  localparam int unsigned TPR_W  = $clog2(MAX_TILES_PER_ROW + 1);
  localparam int unsigned TC_W   = (MAX_TILES_PER_ROW > 1) ? $clog2(MAX_TILES_PER_ROW) : 1;
  localparam int unsigned XS_W   = (TC_W + SIDE_W + 1 > COORD_W) ? TC_W + SIDE_W + 1 : COORD_W;
  localparam int unsigned YS_W   = (ROW_W + SIDE_W + 1 > COORD_W) ? ROW_W + SIDE_W + 1 : COORD_W;

  logic [SIDE_CFG_W-1:0] tile_width;
  logic [SIDE_CFG_W-1:0] tile_height;
  logic [COUNT_W-1:0]    tile_count;

  logic [COUNT_W-1:0] tile_index, tile_index_next;
  logic [CNT_W-1:0]   column_in_tile, column_in_tile_next;
  logic [CNT_W-1:0]   row_in_tile, row_in_tile_next;
  logic [TC_W-1:0]    tile_column, tile_column_next;
  logic [ROW_W-1:0]   tile_row, tile_row_next;

  logic [COUNT_W-1:0] cur_idx;
  logic [CNT_W-1:0]   cur_col, cur_rit;
  logic [TC_W-1:0]    cur_tc;
  logic [ROW_W-1:0]   cur_tr;

  logic [SIDE_W-1:0] tw, th;
  logic [TPR_W-1:0]  tpr;
  logic              accept, active, col_last, row_last, tc_last;
  logic [XS_W-1:0]   xs;
  logic [YS_W-1:0]   ys;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // clamp the tile sides and the tiles per row
  always_comb begin
    if (tile_width == '0) tw = SIDE_W'(1);
    else if (int'(tile_width) > MAX_TILE_SIDE) tw = SIDE_W'(MAX_TILE_SIDE);
    else tw = SIDE_W'(tile_width);
    if (tile_height == '0) th = SIDE_W'(1);
    else if (int'(tile_height) > MAX_TILE_SIDE) th = SIDE_W'(MAX_TILE_SIDE);
    else th = SIDE_W'(tile_height);
    if (int'(tile_count) < MAX_TILES_PER_ROW) tpr = TPR_W'(tile_count);
    else tpr = TPR_W'(MAX_TILES_PER_ROW);
  end

  // first restarts the layout with this byte as pixel zero
  always_comb begin
    cur_idx = first ? '0 : tile_index;
    cur_col = first ? '0 : column_in_tile;
    cur_rit = first ? '0 : row_in_tile;
    cur_tc  = first ? '0 : tile_column;
    cur_tr  = first ? '0 : tile_row;
  end

  assign active   = cur_idx < tile_count;
  assign col_last = (SIDE_W'(cur_col) + SIDE_W'(1)) >= tw;
  assign row_last = (SIDE_W'(cur_rit) + SIDE_W'(1)) >= th;
  assign tc_last  = (TPR_W'(cur_tc) + TPR_W'(1)) >= tpr;

  assign xs = XS_W'(cur_tc) * XS_W'(tw) + XS_W'(cur_col);
  assign ys = YS_W'(cur_tr) * YS_W'(th) + YS_W'(cur_rit);

  always_comb begin
    q_item.x    = xs[COORD_W-1:0];
    q_item.y    = ys[COORD_W-1:0];
    q_item.pix  = pixel_byte;
    q_item.done = col_last && row_last &&
                  ({1'b0, cur_idx} + (COUNT_W+1)'(1) == {1'b0, tile_count});
  end

  assign q_push = accept && active;

  // advance the layout; a dropped byte leaves it where it is
  always_comb begin
    tile_index_next     = cur_idx;
    column_in_tile_next = cur_col;
    row_in_tile_next    = cur_rit;
    tile_column_next    = cur_tc;
    tile_row_next       = cur_tr;
    if (active) begin
      if (!col_last) begin
        column_in_tile_next = cur_col + CNT_W'(1);
      end else begin
        column_in_tile_next = '0;
        if (!row_last) begin
          row_in_tile_next = cur_rit + CNT_W'(1);
        end else begin
          row_in_tile_next = '0;
          tile_index_next  = cur_idx + COUNT_W'(1);
          if (!tc_last) begin
            tile_column_next = cur_tc + TC_W'(1);
          end else begin
            tile_column_next = '0;
            tile_row_next    = cur_tr + ROW_W'(1);
          end
        end
      end
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_wr_en && (cfg_index == REG_TILE_WIDTH ||
                   cfg_index == REG_TILE_HEIGHT || cfg_index == REG_TILE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width  <= RST_TILE_WIDTH;
      tile_height <= RST_TILE_HEIGHT;
      tile_count  <= RST_TILE_COUNT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TILE_WIDTH:  tile_width  <= cfg_wdata[SIDE_CFG_W-1:0];
        REG_TILE_HEIGHT: tile_height <= cfg_wdata[SIDE_CFG_W-1:0];
        REG_TILE_COUNT:  tile_count  <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      tile_index     <= '0;
      column_in_tile <= '0;
      row_in_tile    <= '0;
      tile_column    <= '0;
      tile_row       <= '0;
    end else if (accept) begin
      tile_index     <= tile_index_next;
      column_in_tile <= column_in_tile_next;
      row_in_tile    <= row_in_tile_next;
      tile_column    <= tile_column_next;
      tile_row       <= tile_row_next;
    end
  end

endmodule

// File: rtl/tpu_queue.sv
// short register queue between the front end and the colour stage
// depends on tpu_pkg and the shared assertion macros
`include "tile_pixel_unpacker_core_defines.svh"
module tpu_queue import tpu_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tpu_item_t  push_item,
  input  logic       pop,
  output tpu_item_t  head_item,
  output tpu_qstat_t stat
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tpu_item_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;
  logic               do_push, do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) count_next = count + CNT_W'(1);
    else if (do_pop && !do_push) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
  end

  `TPU_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "queue count above depth")
  `TPU_ASSERT(a_no_push_full, !(push && stat.full), "request pushed into a full queue")
  `TPU_ASSERT_IMP(a_pop_drains, do_pop && !do_push, count == $past(count) - CNT_W'(1), "pop did not drain")
  `TPU_ASSERT(a_ptr_match, (count == '0 || count == CNT_W'(DEPTH)) ? wr_ptr == rd_ptr : wr_ptr != rd_ptr, "pointers disagree with count")

endmodule

// File: rtl/tpu_back.sv
// back end: colour expansion and the output register
// depends on tpu_pkg
module tpu_back import tpu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  tpu_item_t          head_item,
  input  tpu_qstat_t         q_stat,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] pixel_x,
  output logic [COORD_W-1:0] pixel_y,
  output logic [CHAN_W-1:0]  red,
  output logic [CHAN_W-1:0]  green,
  output logic [CHAN_W-1:0]  blue,
  output logic               sheet_done
);

  assign q_pop = !q_stat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // pixel byte is BBGGGRRR
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pixel_x    <= head_item.x;
      pixel_y    <= head_item.y;
      red        <= expand3(head_item.pix[2:0]);
      green      <= expand3(head_item.pix[5:3]);
      blue       <= expand2(head_item.pix[7:6]);
      sheet_done <= head_item.done;
    end
  end

endmodule

// File: tb/tile_pixel_unpacker_core_tb.sv
// self-checking testbench for tile_pixel_unpacker_core: predicts tile layout and
// colour expansion per accepted byte and checks each result in order
// depends on tpu_pkg and the tile_pixel_unpacker_core rtl
`timescale 1ns / 100ps

module tile_pixel_unpacker_core_tb import tpu_pkg::*; ;

  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned IDLE_PAD       = 8;
  localparam int unsigned CYCLE_LIMIT    = 800000;
  localparam int unsigned RANDOM_RESULTS = 250;
  localparam int unsigned LEVEL3_STEP    = 36;
  localparam int unsigned LEVEL2_STEP    = 85;
  localparam int unsigned TILES_PER_ROW  = DEF_MAX_TILES_PER_ROW;
  localparam int unsigned SIDE_LIMIT     = DEF_MAX_TILE_SIDE;

  // index past the register list, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               done;
  } placed_pixel_t;

  class sheet_layout;
    logic [SIDE_CFG_W-1:0] width_cfg;
    logic [SIDE_CFG_W-1:0] height_cfg;
    logic [COUNT_W-1:0]    count_cfg;
    int unsigned           tile_num;
    int unsigned           col;
    int unsigned           row;
    int unsigned           tile_col;
    logic [ROW_W-1:0]      tile_row;
    placed_pixel_t         placed_q[$];
    int unsigned           predicted;
    int unsigned           errors;

    function new();
      width_cfg  = RST_TILE_WIDTH;
      height_cfg = RST_TILE_HEIGHT;
      count_cfg  = RST_TILE_COUNT;
      predicted  = 0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      tile_num = 0;
      col      = 0;
      row      = 0;
      tile_col = 0;
      tile_row = '0;
    endfunction

    function int unsigned side(logic [SIDE_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > SIDE_LIMIT) return SIDE_LIMIT;
      return v;
    endfunction

    function int unsigned sheet_bytes();
      return side(width_cfg) * side(height_cfg) * count_cfg;
    endfunction

    function int unsigned pending();
      return placed_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TILE_WIDTH:  width_cfg = data[SIDE_CFG_W-1:0];
        REG_TILE_HEIGHT: height_cfg = data[SIDE_CFG_W-1:0];
        REG_TILE_COUNT:  count_cfg = data[COUNT_W-1:0];
        default: return;
      endcase
      restart();
    endfunction

    // accepted byte: place it and queue the expected pixel
    function void take_byte(logic [PIX_W-1:0] pix, logic f);
      int unsigned   tw;
      int unsigned   th;
      int unsigned   per_row;
      int unsigned   xpos;
      int unsigned   ypos;
      placed_pixel_t p;
      tw = side(width_cfg);
      th = side(height_cfg);
      per_row = (count_cfg < TILES_PER_ROW) ? count_cfg : TILES_PER_ROW;
      if (f) restart();
      if (tile_num >= count_cfg) return;
      xpos = tile_col * tw + col;
      ypos = tile_row * th + row;
      p.x     = COORD_W'(xpos);
      p.y     = COORD_W'(ypos);
      p.red   = CHAN_W'(pix[2:0] * LEVEL3_STEP);
      p.green = CHAN_W'(pix[5:3] * LEVEL3_STEP);
      p.blue  = CHAN_W'(pix[7:6] * LEVEL2_STEP);
      p.done  = (col + 1 >= tw) && (row + 1 >= th) && (tile_num + 1 == count_cfg);
      placed_q.push_back(p);
      predicted++;
      col++;
      if (col >= tw) begin
        col = 0;
        row++;
        if (row >= th) begin
          row = 0;
          tile_num++;
          tile_col++;
          if (tile_col >= per_row) begin
            tile_col = 0;
            tile_row = tile_row + 1'b1;
          end
        end
      end
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_pixel(placed_pixel_t got);
      placed_pixel_t want;
      if (placed_q.size() == 0) begin
        $error("pixel at x=%0d y=%0d with no request pending", got.x, got.y);
        errors++;
        return;
      end
      want = placed_q.pop_front();
      compare("pixel_x", want.x, got.x);
      compare("pixel_y", want.y, got.y);
      compare("red", want.red, got.red);
      compare("green", want.green, got.green);
      compare("blue", want.blue, got.blue);
      compare("sheet_done", want.done, got.done);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TILE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel_byte = '0;
  logic                  first = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COORD_W-1:0]    pixel_x;
  logic [COORD_W-1:0]    pixel_y;
  logic [CHAN_W-1:0]     red;
  logic [CHAN_W-1:0]     green;
  logic [CHAN_W-1:0]     blue;
  logic                  sheet_done;

  sheet_layout layout;
  bit          steady = 1'b0;
  int unsigned cycle_count = 0;

  tile_pixel_unpacker_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_byte (pixel_byte),
    .first      (first),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .sheet_done (sheet_done)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) layout.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) layout.take_byte(pixel_byte, first);
      if (out_valid && out_ready)
        layout.match_pixel({pixel_x, pixel_y, red, green, blue, sheet_done});
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned ready_run();
    if ($urandom_range(0, 9) == 0) return $urandom_range(100, 300);
    return $urandom_range(1, 12);
  endfunction

  function automatic int unsigned stall_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  // random low five bits for a side register, upper bits random as well
  function automatic logic [CFG_DATA_W-1:0] pick_side();
    int unsigned           r;
    logic [SIDE_CFG_W-1:0] low;
    r = $urandom_range(0, 99);
    if (r < 8) low = '0;
    else if (r < 70) low = SIDE_CFG_W'($urandom_range(1, 4));
    else if (r < 85) low = SIDE_CFG_W'($urandom_range(5, 8));
    else if (r < 93) low = SIDE_CFG_W'(SIDE_LIMIT);
    else low = SIDE_CFG_W'($urandom_range(SIDE_LIMIT + 1, 31));
    return {8'($urandom), low};
  endfunction

  // receiver: ready in stretches with stalls between, unless steady is set
  initial begin
    wait (rst == 1'b0);
    forever begin
      out_ready <= 1'b1;
      repeat (ready_run()) @(posedge clk);
      if (!steady) begin
        out_ready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
    end
  end

  // stop sending and wait for every pending pixel, then pad cycles
  task automatic drain(int unsigned pad);
    in_valid <= 1'b0;
    @(posedge clk);
    while (layout.pending() != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  task automatic feed(logic [PIX_W-1:0] pix, logic f);
    int unsigned gap;
    in_valid   <= 1'b1;
    pixel_byte <= pix;
    first      <= f;
    do @(posedge clk); while (!in_ready);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (!steady && $urandom_range(0, 199) == 0) drain(0);
  endtask

  task automatic send_sheet(int unsigned n, logic lead);
    for (int unsigned i = 0; i < n; i++) feed(8'($urandom), (i == 0) ? lead : 1'b0);
  endtask

  task automatic poke_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_layout(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                             logic [CFG_DATA_W-1:0] c);
    poke_reg(REG_TILE_WIDTH, w);
    poke_reg(REG_TILE_HEIGHT, h);
    poke_reg(REG_TILE_COUNT, c);
  endtask

  task automatic random_sheets();
    int unsigned           base;
    int unsigned           style;
    int unsigned           sheet;
    int unsigned           per_tile;
    int unsigned           r;
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    logic [CFG_DATA_W-1:0] c;
    base = layout.predicted;
    while (layout.predicted < base + RANDOM_RESULTS) begin
      steady = ($urandom_range(0, 4) == 0);
      w = pick_side();
      h = pick_side();
      per_tile = layout.side(w[SIDE_CFG_W-1:0]) * layout.side(h[SIDE_CFG_W-1:0]);
      r = $urandom_range(0, 99);
      if (r < 8) c = '0;
      else if (r < 20 && per_tile <= 2) c = CFG_DATA_W'($urandom_range(60, 70));
      else c = CFG_DATA_W'($urandom_range(1, (64 / per_tile > 1) ? 64 / per_tile : 1));
      if ($urandom_range(0, 4) == 0) poke_reg(REG_NONE, CFG_DATA_W'($urandom));
      load_layout(w, h, c);
      sheet = layout.sheet_bytes();
      style = $urandom_range(0, 9);
      if (sheet == 0 || style >= 8) begin
        // noise: random bytes with the odd restart
        repeat ($urandom_range(1, 12)) feed(8'($urandom), $urandom_range(0, 9) == 0);
      end else begin
        if (style == 7) send_sheet($urandom_range(1, sheet), 1'b1);
        send_sheet(sheet, (style == 7) || ($urandom_range(0, 2) != 0));
        // a few bytes past the end of the sheet
        repeat ($urandom_range(0, 3)) feed(8'($urandom), 1'b0);
      end
      drain(IDLE_PAD);
    end
    steady = 1'b0;
  endtask

  initial begin
    layout = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset layout, 8x8 tiles, one tile; pause mid-stream until drained
    feed(8'h00, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'h07, 1'b0);
    feed(8'h38, 1'b0);
    drain(0);
    feed(8'hC0, 1'b0);
    feed(8'h92, 1'b1);
    drain(IDLE_PAD);

    // zero width taken as one, three tiles; unused index must not restart
    load_layout(13'h1FE0, 13'd1, 13'd3);
    feed(8'h49, 1'b0);
    drain(IDLE_PAD);
    poke_reg(REG_NONE, 13'h1FFF);
    feed(8'hB6, 1'b0);
    feed(8'h24, 1'b0);
    feed(8'hDB, 1'b0);
    feed(8'h6D, 1'b0);
    feed(8'h80, 1'b1);
    drain(IDLE_PAD);

    // small 2x2 tiles across three tiles
    load_layout(13'd2, 13'd2, 13'd3);
    send_sheet(12, 1'b0);
    drain(IDLE_PAD);

    // zero tile count gives no pixels
    load_layout(13'd2, 13'd2, 13'd0);
    feed(8'h11, 1'b1);
    feed(8'h22, 1'b0);
    drain(IDLE_PAD);

    // full rate: oversized width clamped, then tile rows wrapping at 64 per row
    steady = 1'b1;
    load_layout(13'h1FFF, 13'd1, 13'd3);
    send_sheet(50, 1'b1);
    drain(IDLE_PAD);
    load_layout(13'd1, 13'd1, 13'h1FFF);
    send_sheet(140, 1'b1);
    drain(IDLE_PAD);
    steady = 1'b0;

    random_sheets();
    drain(IDLE_PAD);

    if (layout.pending() != 0) $error("%0d pixels never arrived", layout.pending());
    if (layout.errors == 0 && layout.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/tpu_pkg.sv
rtl/tpu_front.sv
rtl/tpu_queue.sv
rtl/tpu_back.sv
rtl/tile_pixel_unpacker_core.sv
tb/tile_pixel_unpacker_core_tb.sv
